>>> sv/giss_pkg.sv
// Shared types and constants for the grayscale smooth/sharpen filter.
// No dependencies; imported by giss_datapath, the top level and the checker.
`timescale 1ns / 1ps

package giss_pkg;

  // Fixed field and port widths
  localparam int PIXEL_W    = 16;
  localparam int DIM_W      = 10;
  localparam int OP_W       = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_PIXEL_BITS = 16;

  // Register reset values
  localparam int RST_WIDTH     = 512;
  localparam int RST_HEIGHT    = 512;
  localparam int RST_MAX_VALUE = 255;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_OPERATION = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_VALUE = 2'd3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PASS    = 2'd0;
  localparam logic [OP_W-1:0] OP_SHARPEN = 2'd1;
  localparam logic [OP_W-1:0] OP_SMOOTH  = 2'd2;

  // Divisor applied in the result stage
  typedef enum logic [1:0] {
    DIV_1,
    DIV_4,
    DIV_6,
    DIV_9
  } giss_div_t;

  // Per-word control handed from the front end to the datapath
  typedef struct packed {
    logic valid;
    logic smooth;
    logic produce;
    logic sharpen;
    logic last;
    logic skip_left;
    logic skip_right;
    logic skip_top;
    logic skip_bottom;
  } giss_ctl_t;

endpackage

>>> sv/giss_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module giss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/giss_datapath.sv
// Line buffers, 3x3 window, sharpen step and rounded-mean divider.
// Depends on giss_pkg and giss_ram.
`timescale 1ns / 1ps

module giss_datapath
  import giss_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  giss_ctl_t                    ctl_a,
  input  logic [PIXEL_BITS-1:0]        pix_a,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_a,
  input  logic [PIXEL_BITS-1:0]        m_max,
  input  logic [PIXEL_BITS-1:0]        t_half,
  output logic                         res_valid,
  output logic [PIXEL_BITS-1:0]        res_pixel,
  output logic                         res_last
);

  localparam int PB = PIXEL_BITS;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int NW = PB + 4;
  localparam int K  = PB + 8;
  localparam logic [K-1:0]  RECIP_6 = K'(((2 ** K) + 5) / 6);
  localparam logic [K-1:0]  RECIP_9 = K'(((2 ** K) + 8) / 9);
  localparam logic [NW-1:0] RND_4   = NW'(2);
  localparam logic [NW-1:0] RND_6   = NW'(3);
  localparam logic [NW-1:0] RND_9   = NW'(4);

  // Stage B: word registers, read data arrives from the line stores
  giss_ctl_t       ctl_b_r;
  logic [PB-1:0]   pix_b_r;
  logic [AW-1:0]   addr_b_r;
  logic [PB-1:0]   up_rd;
  logic [PB-1:0]   lo_rd;
  logic            rd_en;
  logic            wr_en;

  // Two older window columns; slot 0 top row, 2 bottom row
  logic [PB-1:0]   col1_r [3];
  logic [PB-1:0]   col2_r [3];
  logic [PB-1:0]   tap [3][3];
  logic [2:0]      col_use;
  logic [2:0]      row_use;
  logic [NW-1:0]   sum;
  giss_div_t       div_mean;
  logic [PB-1:0]   sharp;
  logic [NW-1:0]   num_nxt;
  giss_div_t       div_nxt;

  // Stage C: result registers
  logic            c_valid_r;
  logic [NW-1:0]   c_num_r;
  giss_div_t       c_div_r;
  logic            c_last_r;
  logic [K-1:0]    recip;
  logic [NW+K-1:0] prod;
  logic [PB-1:0]   quot;

  assign rd_en = en && ctl_a.valid && ctl_a.smooth;
  assign wr_en = en && ctl_b_r.valid && ctl_b_r.smooth;

  // Upper row takes what the lower row held; lower row takes the new pixel
  giss_ram #(
    .WIDTH (PB),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_b_r),
    .wdata (lo_rd),
    .re    (rd_en),
    .raddr (addr_a),
    .rdata (up_rd)
  );

  giss_ram #(
    .WIDTH (PB),
    .DEPTH (MAX_WIDTH)
  ) u_lower (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_b_r),
    .wdata (pix_b_r),
    .re    (rd_en),
    .raddr (addr_a),
    .rdata (lo_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else if (en) begin
      ctl_b_r <= ctl_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_b_r  <= pix_a;
      addr_b_r <= addr_a;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tap[0][k] = col1_r[k];
      tap[1][k] = col2_r[k];
    end
    tap[2][0] = up_rd;
    tap[2][1] = lo_rd;
    tap[2][2] = pix_b_r;
  end

  // Advance the window on every smooth word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < 3; k++) begin
        col1_r[k] <= col2_r[k];
        col2_r[k] <= tap[2][k];
      end
    end
  end

  assign col_use = {!ctl_b_r.skip_right, 1'b1, !ctl_b_r.skip_left};
  assign row_use = {!ctl_b_r.skip_bottom, 1'b1, !ctl_b_r.skip_top};

  always_comb begin
    case ({ctl_b_r.skip_left || ctl_b_r.skip_right, ctl_b_r.skip_top || ctl_b_r.skip_bottom})
      2'b11: begin
        div_mean = DIV_4;
        sum      = RND_4;
      end
      2'b00: begin
        div_mean = DIV_9;
        sum      = RND_9;
      end
      default: begin
        div_mean = DIV_6;
        sum      = RND_6;
      end
    endcase
    // Drop slots that fall outside the frame
    for (int s = 0; s < 3; s++) begin
      for (int k = 0; k < 3; k++) begin
        if (col_use[s] && row_use[k]) begin
          sum = sum + NW'(tap[s][k]);
        end
      end
    end
  end

  always_comb begin
    sharp = pix_b_r;
    if (ctl_b_r.sharpen) begin
      if (pix_b_r <= t_half) begin
        if (pix_b_r != '0) begin
          sharp = pix_b_r - PB'(1);
        end
      end else if (pix_b_r != m_max) begin
        sharp = pix_b_r + PB'(1);
      end
    end
  end

  always_comb begin
    if (ctl_b_r.smooth) begin
      num_nxt = sum;
      div_nxt = div_mean;
    end else begin
      num_nxt = NW'(sharp);
      div_nxt = DIV_1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= ctl_b_r.valid && ctl_b_r.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_num_r  <= num_nxt;
      c_div_r  <= div_nxt;
      c_last_r <= ctl_b_r.last;
    end
  end

  // Divide by 6 or 9 through a scaled reciprocal; exact over the sum range
  assign recip = (c_div_r == DIV_6) ? RECIP_6 : RECIP_9;
  assign prod  = (NW + K)'(c_num_r) * (NW + K)'(recip);

  always_comb begin
    case (c_div_r)
      DIV_1:   quot = c_num_r[PB-1:0];
      DIV_4:   quot = c_num_r[PB+1:2];
      DIV_6:   quot = prod[K +: PB];
      DIV_9:   quot = prod[K +: PB];
      default: quot = c_num_r[PB-1:0];
    endcase
  end

  assign res_valid = c_valid_r;
  assign res_pixel = quot;
  assign res_last  = c_last_r;

endmodule

>>> sv/gray_image_smooth_sharpen_top.sv
// A result passes the datapath's stage B and stage C registers before it is pushed to the output register;
// in smooth mode results trail the input by one row plus one pixel, flushed by drain words.
// Throughput: one word per clock while the output queue has room; each line store is read once per word.
// A two-entry output queue lets input continue for one result while the output stalls.
// Reset (rst_n, synchronous, active low) clears counters, pipeline valids and the queue,
// and loads register defaults; the line stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps

// Top level: configuration registers, frame position counters and output queue.
// Depends on giss_pkg and giss_datapath.
module gray_image_smooth_sharpen_top
  import giss_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIXEL_W-1:0]    in_tdata,   // [15:0] pixel_in
  input  logic [0:0]            in_tuser,   // [0] drain
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIXEL_W-1:0]    out_tdata,  // [15:0] pixel_out
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PB      = PIXEL_BITS;
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int RW      = $clog2(MAX_HEIGHT + 2);
  localparam int ORW     = $clog2(MAX_HEIGHT);
  localparam int PIX_MAX = (2 ** PB) - 1;
  localparam int W_RST   = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
  localparam int H_RST   = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;
  localparam int M_RST   = (RST_MAX_VALUE > PIX_MAX) ? PIX_MAX : RST_MAX_VALUE;

  // Configuration
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [WW-1:0]    w_r, w_nxt, w_clamp;
  logic [HW-1:0]    h_r, h_nxt, h_clamp;
  logic [PB-1:0]    m_r, m_nxt, m_clamp;
  logic [PB-1:0]    t_r;
  logic [DIM_W-1:0] dim_v;
  logic [PIXEL_W-1:0] max_v;
  logic             cfg_restart;
  logic             op_smooth;
  logic             op_sharpen;

  // Frame position
  logic [CW-1:0]    col_r, col_nxt, col_step, ocol_r, ocol_nxt, ocol_step;
  logic [RW-1:0]    row_r, row_nxt, row_step;
  logic [ORW-1:0]   orow_r, orow_nxt, orow_step;
  logic             col_end, row_end, ocol_end, orow_end;
  logic             flush, at_output;

  // Front end
  logic             en, acc, drain;
  logic [PB-1:0]    pix_v, pix_c, pix_a;
  giss_ctl_t        ctl_a;

  // Datapath result and output queue
  logic             res_valid, res_last;
  logic [PB-1:0]    res_pixel;
  logic             push, pop;
  logic             out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic [PIXEL_W-1:0] out_pix_r, out_pix_nxt, skid_pix_r, skid_pix_nxt;
  logic             out_last_r, out_last_nxt, skid_last_r, skid_last_nxt;

  assign en        = !skid_valid_r;
  assign in_tready = en;
  assign acc       = in_tvalid && en;
  assign drain     = in_tuser[0];

  // ---------------------------------------------------------------- config
  assign dim_v = cfg_wdata[DIM_W-1:0];
  assign max_v = cfg_wdata[PIXEL_W-1:0];

  always_comb begin
    if (dim_v < DIM_W'(2)) begin
      w_clamp = WW'(2);
    end else if (int'(dim_v) > MAX_WIDTH) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(dim_v);
    end
    if (dim_v < DIM_W'(2)) begin
      h_clamp = HW'(2);
    end else if (int'(dim_v) > MAX_HEIGHT) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(dim_v);
    end
    if (max_v == '0) begin
      m_clamp = PB'(1);
    end else if (int'(max_v) > PIX_MAX) begin
      m_clamp = PB'(PIX_MAX);
    end else begin
      m_clamp = PB'(max_v);
    end
  end

  always_comb begin
    op_nxt      = op_r;
    w_nxt       = w_r;
    h_nxt       = h_r;
    m_nxt       = m_r;
    cfg_restart = 1'b0;
    if (cfg_we) begin
      case (cfg_addr)
        REG_OPERATION: begin
          op_nxt      = cfg_wdata[OP_W-1:0];
          cfg_restart = 1'b1;
        end
        REG_WIDTH: begin
          w_nxt       = w_clamp;
          cfg_restart = 1'b1;
        end
        REG_HEIGHT: begin
          h_nxt       = h_clamp;
          cfg_restart = 1'b1;
        end
        REG_MAX_VALUE: begin
          m_nxt       = m_clamp;
          cfg_restart = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_PASS;
      w_r  <= WW'(W_RST);
      h_r  <= HW'(H_RST);
      m_r  <= PB'(M_RST);
      t_r  <= PB'(M_RST / 2);
    end else begin
      op_r <= op_nxt;
      w_r  <= w_nxt;
      h_r  <= h_nxt;
      m_r  <= m_nxt;
      t_r  <= m_nxt >> 1;
    end
  end

  // Unused code acts as pass through
  always_comb begin
    op_smooth  = 1'b0;
    op_sharpen = 1'b0;
    case (op_r)
      OP_SMOOTH:  op_smooth  = 1'b1;
      OP_SHARPEN: op_sharpen = 1'b1;
      OP_PASS:    ;
      default:    ;
    endcase
  end

  // ---------------------------------------------------------------- position
  assign pix_v = in_tdata[PB-1:0];
  assign pix_c = (pix_v > m_r) ? m_r : pix_v;

  assign col_end  = (WW'(col_r) + WW'(1)) == w_r;
  assign row_end  = (row_r + RW'(1)) == RW'(h_r);
  assign ocol_end = (WW'(ocol_r) + WW'(1)) == w_r;
  assign orow_end = (HW'(orow_r) + HW'(1)) == h_r;

  assign flush     = row_r >= RW'(h_r);
  assign at_output = (row_r >= RW'(2)) || ((row_r == RW'(1)) && (col_r != '0));

  assign col_step  = col_end ? '0 : col_r + CW'(1);
  assign row_step  = col_end ? row_r + RW'(1) : row_r;
  assign ocol_step = ocol_end ? '0 : ocol_r + CW'(1);
  assign orow_step = ocol_end ? orow_r + ORW'(1) : orow_r;

  always_comb begin
    ctl_a    = '0;
    pix_a    = pix_c;
    col_nxt  = col_r;
    row_nxt  = row_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (acc) begin
      if (op_smooth) begin
        // After the last pixel is in, every word is a drain word
        if (flush || !drain) begin
          ctl_a.valid  = 1'b1;
          ctl_a.smooth = 1'b1;
          if (flush) begin
            pix_a = '0;
          end
          if (at_output) begin
            ctl_a.produce     = 1'b1;
            ctl_a.last        = ocol_end && orow_end;
            ctl_a.skip_left   = (ocol_r == '0);
            ctl_a.skip_right  = ocol_end;
            ctl_a.skip_top    = (orow_r == '0);
            ctl_a.skip_bottom = orow_end;
            if (ocol_end && orow_end) begin
              col_nxt  = '0;
              row_nxt  = '0;
              ocol_nxt = '0;
              orow_nxt = '0;
            end else begin
              ocol_nxt = ocol_step;
              orow_nxt = orow_step;
              col_nxt  = col_step;
              row_nxt  = row_step;
            end
          end else begin
            col_nxt = col_step;
            row_nxt = row_step;
          end
        end
      end else if (!drain) begin
        ctl_a.valid   = 1'b1;
        ctl_a.produce = 1'b1;
        ctl_a.sharpen = op_sharpen;
        ctl_a.last    = col_end && row_end;
        if (col_end && row_end) begin
          col_nxt = '0;
          row_nxt = '0;
        end else begin
          col_nxt = col_step;
          row_nxt = row_step;
        end
      end
    end
    // Any register write restarts the frame
    if (cfg_restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
    end
  end

  giss_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl_a     (ctl_a),
    .pix_a     (pix_a),
    .addr_a    (col_r),
    .m_max     (m_r),
    .t_half    (t_r),
    .res_valid (res_valid),
    .res_pixel (res_pixel),
    .res_last  (res_last)
  );

  // ---------------------------------------------------------------- output queue
  assign push = en && res_valid;
  assign pop  = out_valid_r && out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_pix_nxt    = out_pix_r;
    out_last_nxt   = out_last_r;
    skid_valid_nxt = skid_valid_r;
    skid_pix_nxt   = skid_pix_r;
    skid_last_nxt  = skid_last_r;
    if (skid_valid_r) begin
      // Pipeline is held; only drain the skid word forward
      if (pop) begin
        out_pix_nxt    = skid_pix_r;
        out_last_nxt   = skid_last_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_nxt = 1'b1;
        out_pix_nxt   = PIXEL_W'(res_pixel);
        out_last_nxt  = res_last;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_pix_nxt   = PIXEL_W'(res_pixel);
        skid_last_nxt  = res_last;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r   <= out_pix_nxt;
    out_last_r  <= out_last_nxt;
    skid_pix_r  <= skid_pix_nxt;
    skid_last_r <= skid_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule

>>> sv/giss_checker.sv
// Port-level checks for the smooth/sharpen filter and the bind that attaches them.
// Depends on giss_pkg and gray_image_smooth_sharpen_top.
`timescale 1ns / 1ps

module giss_checker
  import giss_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [PIXEL_W-1:0] out_tdata,
  input logic               out_tlast
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // Input is open right after reset
  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_tready)
    else $error("input not ready after reset");

  // Input only closes while a result word is waiting
  a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input held without a pending result word");

  // Input closes only after the output refused a word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input closed without output back-pressure");

endmodule

bind gray_image_smooth_sharpen_top giss_checker u_giss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
